// ----- src/crpb_pkg.sv -----
// ----------------------------------------------------------------------------
// crpb_pkg
// shared types and constants of the credit ring playback buffer
// ----------------------------------------------------------------------------
package crpb_pkg;

  localparam int RING_BYTES_DEF  = 16384;
  localparam int CHUNK_BYTES_DEF = 1024;

  localparam int CNT_W    = 24;
  localparam int CIDX_W   = 14;
  localparam int CLEN_W   = 15;
  localparam int PRE_W    = 15;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 3;
  localparam int BYTE_W   = 8;

  localparam logic [PRE_W-1:0] PRE_RESET = PRE_W'(8192);

  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_BEGIN  = 3'd0,
    K_HEADER = 3'd1,
    K_DATA   = 3'd2,
    K_TAKE   = 3'd3,
    K_TICK   = 3'd4,
    K_FINISH = 3'd5,
    K_ABORT  = 3'd6
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO_LEN = 3'd1,
    ST_ORDER    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_INACTIVE = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                byte_valid;
    logic [BYTE_W-1:0]   speaker_byte;
    logic                grant_valid;
    logic [CIDX_W-1:0]   grant_index;
    logic                open_speaker;
    logic                close_speaker;
    logic                done_valid;
    logic                done_success;
  } res_t;

endpackage

// ----- src/crpb_ram.sv -----
// ----------------------------------------------------------------------------
// crpb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module crpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/crpb_out_fifo.sv -----
// ----------------------------------------------------------------------------
// crpb_out_fifo
// small result queue that decouples the output stall from the input side
// ----------------------------------------------------------------------------
module crpb_out_fifo
  import crpb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  input  logic pending,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  res_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp;
  logic [OQ_PTR_W-1:0] rp;
  logic [OQ_PTR_W-1:0] cnt;
  logic [OQ_PTR_W-1:0] cnt_next;
  logic                pop;

  assign out_valid = (cnt != '0);
  assign out_res   = mem[rp];
  assign pop       = out_valid && !out_stall;
  assign full      = (3'(cnt) + 3'(pending)) >= 3'(OQ_DEPTH);

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + OQ_PTR_W'(1);
    end else if (pop && !push) begin
      cnt_next = cnt - OQ_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wp <= (wp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wp + OQ_PTR_W'(1);
      end
      if (pop) begin
        rp <= (rp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rp + OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_res;
    end
  end

endmodule

// ----- src/credit_ring_playback_buffer.sv -----
// ----------------------------------------------------------------------------
// credit_ring_playback_buffer
// credit controlled ring buffer for one playback phrase
// ----------------------------------------------------------------------------
// The block takes one input word per clock unless stalled and gives one result
// word for each via the read stage and queue. Payload bytes go into a ring of
// RING_BYTES entries and speaker takes read it through the memory's registered
// read port; all counters sit in flip-flops and are updated in the cycle a
// word is accepted, so consecutive words never wait on each other. A three
// entry result queue keeps the input open while a result waits at the output;
// the input stalls once the queue and the read stage together hold three
// words. The ring needs no clearing after reset, since only written entries
// are ever read. RING_BYTES and CHUNK_BYTES must be powers of two.
module credit_ring_playback_buffer
  import crpb_pkg::*;
#(
  parameter int RING_BYTES  = RING_BYTES_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PRE_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [CNT_W-1:0]  phrase_bytes,
  input  logic [CIDX_W-1:0] chunk_seq,
  input  logic [CLEN_W-1:0] chunk_len,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              outbox_ready,
  input  logic              finish_done,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic              byte_valid,
  output logic [BYTE_W-1:0] speaker_byte,
  output logic              grant_valid,
  output logic [CIDX_W-1:0] grant_index,
  output logic              open_speaker,
  output logic              close_speaker,
  output logic              done_valid,
  output logic              done_success
);

  localparam int AW    = $clog2(RING_BYTES);
  localparam int SH    = $clog2(CHUNK_BYTES);
  localparam int GW    = CNT_W + 1 - SH;
  localparam int BATCH = (RING_BYTES / CHUNK_BYTES) / 2;
  localparam int OW    = CIDX_W + SH;

  // session state
  logic [CNT_W-1:0]  phrase_total, phrase_total_next;
  logic [CNT_W-1:0]  bytes_received, bytes_received_next;
  logic [CNT_W-1:0]  bytes_played, bytes_played_next;
  logic [GW-1:0]     chunk_total, chunk_total_next;
  logic [GW-1:0]     grant_mark, grant_mark_next;
  logic [CLEN_W-1:0] chunk_bytes_left, chunk_bytes_left_next;
  logic              session_active, session_active_next;
  logic              speaker_is_open, speaker_is_open_next;
  logic              stream_closed, stream_closed_next;
  logic [AW-1:0]     wr_ptr, wr_ptr_next;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic [PRE_W-1:0]  prebuffer;

  logic              accept;
  logic              live;
  res_t              res;
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_q;

  logic              p1_valid;
  res_t              p1_res;
  res_t              p1_full_res;
  res_t              q_res;
  logic              q_full;

  // grant unit
  logic [CNT_W-1:0]  g_bp;
  logic [GW-1:0]     g_ct;
  logic [GW-1:0]     g_mark;
  logic [CNT_W:0]    g_sum;
  logic [GW-1:0]     g_raw;
  logic [GW-1:0]     g_cap;
  logic              g_ok;

  // begin, header, data and take helpers
  logic [CNT_W:0]    tl_round;
  logic [GW-1:0]     ct_new;
  logic [OW-1:0]     cidx_off;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W:0]    fill_sum;
  logic [CNT_W:0]    recv_sum;
  logic [CNT_W-1:0]  br_inc;
  logic [CNT_W-1:0]  bp_inc;
  logic [CNT_W-1:0]  open_br;
  logic              open_hit;

  assign accept = in_valid && !in_stall;
  assign live   = session_active && !stream_closed;

  assign tl_round = {1'b0, phrase_bytes} + (CNT_W + 1)'(CHUNK_BYTES - 1);
  assign ct_new   = GW'(tl_round >> SH);

  assign g_bp   = (kind_t'(kind) == K_BEGIN) ? '0 : bytes_played;
  assign g_ct   = (kind_t'(kind) == K_BEGIN) ? ct_new : chunk_total;
  assign g_mark = (kind_t'(kind) == K_BEGIN) ? '0 : grant_mark;
  assign g_sum  = {1'b0, g_bp} + (CNT_W + 1)'(RING_BYTES);
  assign g_raw  = GW'(g_sum >> SH);
  assign g_cap  = (g_raw > g_ct) ? g_ct : g_raw;
  assign g_ok   = (g_ct != '0) && (g_cap > g_mark) && outbox_ready &&
                  (((g_cap - g_mark) >= GW'(BATCH)) || (g_cap == g_ct));

  assign cidx_off = {chunk_seq, SH'(0)};
  assign fill     = bytes_received - bytes_played;
  assign fill_sum = (CNT_W + 1)'(fill) + (CNT_W + 1)'(chunk_len);
  assign recv_sum = (CNT_W + 1)'(bytes_received) + (CNT_W + 1)'(chunk_len);
  assign br_inc   = bytes_received + CNT_W'(1);
  assign bp_inc   = bytes_played + CNT_W'(1);
  assign open_br  = (kind_t'(kind) == K_DATA) ? br_inc : bytes_received;
  assign open_hit = !speaker_is_open &&
                    ((open_br >= CNT_W'(prebuffer)) || (open_br >= phrase_total));

  always_comb begin
    phrase_total_next     = phrase_total;
    bytes_received_next   = bytes_received;
    bytes_played_next     = bytes_played;
    chunk_total_next      = chunk_total;
    grant_mark_next       = grant_mark;
    chunk_bytes_left_next = chunk_bytes_left;
    session_active_next   = session_active;
    speaker_is_open_next  = speaker_is_open;
    stream_closed_next    = stream_closed;
    wr_ptr_next           = wr_ptr;
    rd_ptr_next           = rd_ptr;
    res                   = '0;
    res.status            = ST_OK;
    ram_we                = 1'b0;
    ram_re                = 1'b0;
    case (kind_t'(kind))
      K_BEGIN: begin
        phrase_total_next     = '0;
        bytes_received_next   = '0;
        bytes_played_next     = '0;
        chunk_total_next      = '0;
        grant_mark_next       = '0;
        chunk_bytes_left_next = '0;
        session_active_next   = 1'b0;
        speaker_is_open_next  = 1'b0;
        stream_closed_next    = 1'b0;
        wr_ptr_next           = '0;
        rd_ptr_next           = '0;
        if (phrase_bytes == '0) begin
          res.status = ST_ZERO_LEN;
        end else begin
          phrase_total_next   = phrase_bytes;
          chunk_total_next    = ct_new;
          session_active_next = 1'b1;
          if (g_ok) begin
            grant_mark_next = g_cap;
            res.grant_valid = 1'b1;
            res.grant_index = CIDX_W'(g_cap - GW'(1));
          end
        end
      end
      K_HEADER: begin
        if (!live) begin
          res.status = ST_INACTIVE;
        end else if ((chunk_bytes_left != '0) ||
                     (32'(cidx_off) != 32'(bytes_received))) begin
          res.status = ST_ORDER;
        end else if ((fill_sum > (CNT_W + 1)'(RING_BYTES)) || recv_sum[CNT_W]) begin
          res.status = ST_OVERFLOW;
        end else begin
          chunk_bytes_left_next = chunk_len;
          if ((chunk_len == '0) && open_hit) begin
            speaker_is_open_next = 1'b1;
            res.open_speaker     = 1'b1;
          end
        end
      end
      K_DATA: begin
        if (!live) begin
          res.status = ST_INACTIVE;
        end else if (chunk_bytes_left == '0) begin
          res.status = ST_ORDER;
        end else begin
          ram_we                = 1'b1;
          bytes_received_next   = br_inc;
          wr_ptr_next           = (wr_ptr == AW'(RING_BYTES - 1)) ? '0 : wr_ptr + AW'(1);
          chunk_bytes_left_next = chunk_bytes_left - CLEN_W'(1);
          if ((chunk_bytes_left == CLEN_W'(1)) && open_hit) begin
            speaker_is_open_next = 1'b1;
            res.open_speaker     = 1'b1;
          end
        end
      end
      K_TAKE: begin
        if (!live || !speaker_is_open) begin
          res.status = ST_INACTIVE;
        end else if (bytes_played >= bytes_received) begin
          res.status = ST_EMPTY;
        end else begin
          ram_re            = 1'b1;
          res.byte_valid    = 1'b1;
          bytes_played_next = bp_inc;
          rd_ptr_next       = (rd_ptr == AW'(RING_BYTES - 1)) ? '0 : rd_ptr + AW'(1);
          if (bp_inc >= phrase_total) begin
            stream_closed_next = 1'b1;
            res.close_speaker  = 1'b1;
          end
        end
      end
      K_TICK: begin
        if (!session_active) begin
          res.status = ST_INACTIVE;
        end else if (!stream_closed && g_ok) begin
          grant_mark_next = g_cap;
          res.grant_valid = 1'b1;
          res.grant_index = CIDX_W'(g_cap - GW'(1));
        end
      end
      K_FINISH: begin
        if (!session_active || !speaker_is_open) begin
          res.status = ST_INACTIVE;
        end else begin
          res.done_valid        = 1'b1;
          res.done_success      = finish_done && (bytes_played >= phrase_total);
          phrase_total_next     = '0;
          bytes_received_next   = '0;
          bytes_played_next     = '0;
          chunk_total_next      = '0;
          grant_mark_next       = '0;
          chunk_bytes_left_next = '0;
          session_active_next   = 1'b0;
          speaker_is_open_next  = 1'b0;
          stream_closed_next    = 1'b0;
          wr_ptr_next           = '0;
          rd_ptr_next           = '0;
        end
      end
      K_ABORT: begin
        phrase_total_next     = '0;
        bytes_received_next   = '0;
        bytes_played_next     = '0;
        chunk_total_next      = '0;
        grant_mark_next       = '0;
        chunk_bytes_left_next = '0;
        session_active_next   = 1'b0;
        speaker_is_open_next  = 1'b0;
        stream_closed_next    = 1'b0;
        wr_ptr_next           = '0;
        rd_ptr_next           = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phrase_total     <= '0;
      bytes_received   <= '0;
      bytes_played     <= '0;
      chunk_total      <= '0;
      grant_mark       <= '0;
      chunk_bytes_left <= '0;
      session_active   <= 1'b0;
      speaker_is_open  <= 1'b0;
      stream_closed    <= 1'b0;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
      prebuffer        <= PRE_RESET;
      p1_valid         <= 1'b0;
    end else begin
      if (accept) begin
        phrase_total     <= phrase_total_next;
        bytes_received   <= bytes_received_next;
        bytes_played     <= bytes_played_next;
        chunk_total      <= chunk_total_next;
        grant_mark       <= grant_mark_next;
        chunk_bytes_left <= chunk_bytes_left_next;
        session_active   <= session_active_next;
        speaker_is_open  <= speaker_is_open_next;
        stream_closed    <= stream_closed_next;
        wr_ptr           <= wr_ptr_next;
        rd_ptr           <= rd_ptr_next;
      end
      if (cfg_we) begin
        prebuffer <= cfg_data;
      end
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_res <= res;
    end
  end

  crpb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (wr_ptr),
    .wdata (data_byte),
    .re    (accept && ram_re),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  // merge the ring read data into the result word
  always_comb begin
    p1_full_res              = p1_res;
    p1_full_res.speaker_byte = p1_res.byte_valid ? ram_q : '0;
  end

  crpb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p1_valid),
    .push_res  (p1_full_res),
    .pending   (p1_valid),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (q_res)
  );

  assign in_stall      = q_full;
  assign status        = q_res.status;
  assign byte_valid    = q_res.byte_valid;
  assign speaker_byte  = q_res.speaker_byte;
  assign grant_valid   = q_res.grant_valid;
  assign grant_index   = q_res.grant_index;
  assign open_speaker  = q_res.open_speaker;
  assign close_speaker = q_res.close_speaker;
  assign done_valid    = q_res.done_valid;
  assign done_success  = q_res.done_success;

endmodule
